>>> rtl/rssd_pkg.sv
// rssd_pkg: shared types, codes and constants for record_stack_sorted_drain.
// No dependencies.
package rssd_pkg;

  localparam int DEPTH_DEF  = 32;
  localparam int NAME_WORDS = 5;
  localparam int NAME_BYTES = 40;
  localparam int REC_W      = 64 * (NAME_WORDS + 1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_DRAIN = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RD,
    S_DR_RD,
    S_DR_LOAD,
    S_INS_FETCH,
    S_INS_HOLD,
    S_INS_CMP,
    S_INS_PUT,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_RESP
  } state_t;

  // true when name a orders strictly after name b (strcmp style)
  function automatic logic name_after(input logic [319:0] a, input logic [319:0] b);
    logic done;
    logic res;
    logic [7:0] x;
    logic [7:0] y;
    done = 1'b0;
    res  = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      x = a[319 - 8*i -: 8];
      y = b[319 - 8*i -: 8];
      if (!done) begin
        if (x != y) begin
          res  = (x > y);
          done = 1'b1;
        end else if (x == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/rssd_if.sv
// rssd_if: valid/ready channel interfaces for the input and result beats.
// Depends on nothing.
interface rssd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] name_word_0;
  logic [63:0] name_word_1;
  logic [63:0] name_word_2;
  logic [63:0] name_word_3;
  logic [63:0] name_word_4;
  logic [63:0] phone_word;
  modport source (output valid, operation, name_word_0, name_word_1, name_word_2,
                  name_word_3, name_word_4, phone_word, input ready);
  modport sink (input valid, operation, name_word_0, name_word_1, name_word_2,
                name_word_3, name_word_4, phone_word, output ready);
endinterface

interface rssd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] out_name_0;
  logic [63:0] out_name_1;
  logic [63:0] out_name_2;
  logic [63:0] out_name_3;
  logic [63:0] out_name_4;
  logic [63:0] out_phone;
  logic [4:0]  position;
  logic        last;
  modport source (output valid, status, out_name_0, out_name_1, out_name_2,
                  out_name_3, out_name_4, out_phone, position, last, input ready);
  modport sink (input valid, status, out_name_0, out_name_1, out_name_2,
                out_name_3, out_name_4, out_phone, position, last, output ready);
endinterface

>>> rtl/rssd_ram.sv
// rssd_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module rssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/record_stack_sorted_drain.sv
// record_stack_sorted_drain: top level, sequencer plus two record memories.
// Depends on rssd_pkg, rssd_if, rssd_ram.
//
// Usage: a stack of up to DEPTH records (40-byte name, 8-byte phone).
// Input channel in (beat: operation + record). Result channel out.
// Push gives one beat: ok, or full status. Pop gives one beat with the top
// record, or empty status. Drain sorts all records ascending by name (ties:
// newest first) and emits one beat per record with position and last on the
// final beat, then the stack is empty; draining an empty stack gives one
// empty-status beat. Operation code 3 is dropped with no beat.
// One item is in flight at a time. Push: S_RESP gives the result. Pop: the
// top record is read in S_POP_RD, then S_RESP gives it. The next input is
// taken the cycle after the last result beat is accepted; after a drain of
// records the sequencer first leaves S_RESP. Drain of n records: each one is
// copied to the sort memory, each after the first is inserted (fetch, hold,
// compares, put), each emitted. The compares, one per cycle, set drain time.
// Reset (synchronous, rst_n low) empties the stack; memories keep contents.
// A stalled receiver (out.ready low) holds the current result beat and the
// sequencer waits; no input is taken until the item is fully delivered.
module record_stack_sorted_drain #(
  parameter int DEPTH = rssd_pkg::DEPTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  rssd_in_if.sink  in_ch,
  rssd_out_if.source out_ch
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // stack memory and sort scratch memory, one record per entry
  logic                    sk_we, so_we;
  logic [AW-1:0]           sk_wa, sk_ra, so_wa, so_ra;
  logic [rssd_pkg::REC_W-1:0] sk_wd, sk_rd, so_wd, so_rd;

  rssd_ram #(.WIDTH(rssd_pkg::REC_W), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));
  rssd_ram #(.WIDTH(rssd_pkg::REC_W), .DEPTH(DEPTH)) u_sort (
    .clk(clk), .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));

  rssd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;       // records in drain
  logic [CW-1:0] i_r, i_nxt;       // outer index / copy index / emit index
  logic [CW-1:0] j_r, j_nxt;       // insertion slot
  logic [rssd_pkg::REC_W-1:0] held_r, held_nxt;
  logic [rssd_pkg::REC_W-1:0] ob_rec_r, ob_rec_nxt;
  logic [1:0] ob_st_r, ob_st_nxt;
  logic [4:0] ob_pos_r, ob_pos_nxt;
  logic ob_last_r, ob_last_nxt;
  logic ov_r, ov_nxt;

  logic in_fire, out_fire;
  logic [rssd_pkg::REC_W-1:0] in_rec;
  logic after;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;
  assign in_rec = {in_ch.name_word_0, in_ch.name_word_1, in_ch.name_word_2,
                   in_ch.name_word_3, in_ch.name_word_4, in_ch.phone_word};
  // slot j-1 (just read) against the record being inserted
  assign after = rssd_pkg::name_after(so_rd[rssd_pkg::REC_W-1:64], held_r[rssd_pkg::REC_W-1:64]);

  assign in_ch.ready = (state_r == rssd_pkg::S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.status = ob_st_r;
  assign out_ch.out_name_0 = ob_rec_r[383:320];
  assign out_ch.out_name_1 = ob_rec_r[319:256];
  assign out_ch.out_name_2 = ob_rec_r[255:192];
  assign out_ch.out_name_3 = ob_rec_r[191:128];
  assign out_ch.out_name_4 = ob_rec_r[127:64];
  assign out_ch.out_phone  = ob_rec_r[63:0];
  assign out_ch.position = ob_pos_r;
  assign out_ch.last = ob_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rssd_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (rssd_pkg::op_t'(in_ch.operation))
            rssd_pkg::OP_PUSH:  state_nxt = rssd_pkg::S_RESP;
            rssd_pkg::OP_POP:   state_nxt = (count_r == '0) ? rssd_pkg::S_RESP
                                                             : rssd_pkg::S_POP_RD;
            rssd_pkg::OP_DRAIN: state_nxt = (count_r == '0) ? rssd_pkg::S_RESP
                                                             : rssd_pkg::S_DR_RD;
            rssd_pkg::OP_NONE:  state_nxt = rssd_pkg::S_IDLE;
            default:            state_nxt = rssd_pkg::S_IDLE;
          endcase
        end
      end
      rssd_pkg::S_POP_RD:  state_nxt = rssd_pkg::S_RESP;
      rssd_pkg::S_DR_RD:   state_nxt = rssd_pkg::S_DR_LOAD;
      rssd_pkg::S_DR_LOAD: begin
        if (i_r + 1'b1 == n_r) begin
          state_nxt = (n_r == CW'(1)) ? rssd_pkg::S_EMIT_RD : rssd_pkg::S_INS_FETCH;
        end else begin
          state_nxt = rssd_pkg::S_DR_RD;
        end
      end
      rssd_pkg::S_INS_FETCH: state_nxt = rssd_pkg::S_INS_HOLD;
      rssd_pkg::S_INS_HOLD:  state_nxt = rssd_pkg::S_INS_CMP;
      rssd_pkg::S_INS_CMP: state_nxt = (after && j_r != CW'(1)) ? rssd_pkg::S_INS_CMP
                                                                : rssd_pkg::S_INS_PUT;
      rssd_pkg::S_INS_PUT: state_nxt = (i_r + 1'b1 == n_r) ? rssd_pkg::S_EMIT_RD
                                                            : rssd_pkg::S_INS_FETCH;
      rssd_pkg::S_EMIT_RD: state_nxt = rssd_pkg::S_EMIT_OUT;
      rssd_pkg::S_EMIT_OUT: begin
        if (!ov_r) begin
          state_nxt = (i_r + 1'b1 == n_r) ? rssd_pkg::S_RESP : rssd_pkg::S_EMIT_RD;
        end
      end
      rssd_pkg::S_RESP: if (!ov_r) state_nxt = rssd_pkg::S_IDLE;
      default: state_nxt = rssd_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_nxt = count_r;
    n_nxt = n_r;
    i_nxt = i_r;
    j_nxt = j_r;
    held_nxt = held_r;
    ob_rec_nxt = ob_rec_r;
    ob_st_nxt = ob_st_r;
    ob_pos_nxt = ob_pos_r;
    ob_last_nxt = ob_last_r;
    ov_nxt = ov_r & ~out_fire;
    sk_we = 1'b0;
    sk_wa = count_r[AW-1:0];
    sk_wd = in_rec;
    sk_ra = '0;
    so_we = 1'b0;
    so_wa = '0;
    so_wd = sk_rd;
    so_ra = '0;
    unique case (state_r)
      rssd_pkg::S_IDLE: begin
        if (in_fire) begin
          ob_rec_nxt = '0;
          ob_pos_nxt = '0;
          ob_last_nxt = 1'b1;
          ob_st_nxt = rssd_pkg::ST_OK;
          unique case (rssd_pkg::op_t'(in_ch.operation))
            rssd_pkg::OP_PUSH: begin
              if (count_r == CW'(DEPTH)) begin
                ob_st_nxt = rssd_pkg::ST_FULL;
              end else begin
                sk_we = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            rssd_pkg::OP_POP: begin
              if (count_r == '0) begin
                ob_st_nxt = rssd_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                sk_ra = AW'(count_r - 1'b1);
              end
            end
            rssd_pkg::OP_DRAIN: begin
              if (count_r == '0) begin
                ob_st_nxt = rssd_pkg::ST_EMPTY;
              end else begin
                n_nxt = count_r;
                i_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      rssd_pkg::S_POP_RD: ob_rec_nxt = sk_rd;
      rssd_pkg::S_DR_RD: sk_ra = AW'(n_r - 1'b1 - i_r);
      rssd_pkg::S_DR_LOAD: begin
        so_we = 1'b1;
        so_wa = i_r[AW-1:0];
        so_wd = sk_rd;
        if (i_r + 1'b1 == n_r) begin
          count_nxt = '0;
          i_nxt = (n_r == CW'(1)) ? '0 : CW'(1);
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      // fetch record i, hold it, then walk j down from i
      rssd_pkg::S_INS_FETCH: so_ra = i_r[AW-1:0];
      rssd_pkg::S_INS_HOLD: begin
        held_nxt = so_rd;
        j_nxt = i_r;
        so_ra = AW'(i_r - 1'b1);
      end
      rssd_pkg::S_INS_CMP: begin
        if (after) begin
          // shift slot j-1 up, read slot j-2 for the next compare
          so_we = 1'b1;
          so_wa = j_r[AW-1:0];
          so_wd = so_rd;
          j_nxt = j_r - 1'b1;
          so_ra = AW'(j_r - 2'd2);
        end
      end
      rssd_pkg::S_INS_PUT: begin
        so_we = 1'b1;
        so_wa = j_r[AW-1:0];
        so_wd = held_r;
        i_nxt = (i_r + 1'b1 == n_r) ? '0 : i_r + 1'b1;
      end
      // keep the read address while the output beat waits
      rssd_pkg::S_EMIT_RD, rssd_pkg::S_EMIT_OUT: so_ra = i_r[AW-1:0];
      default: ;
    endcase

    if (state_r == rssd_pkg::S_EMIT_OUT && !ov_r) begin
      ob_rec_nxt = so_rd;
      ob_st_nxt = rssd_pkg::ST_OK;
      ob_pos_nxt = 5'(i_r);
      ob_last_nxt = (i_r + 1'b1 == n_r);
      ov_nxt = 1'b1;
      i_nxt = i_r + 1'b1;
    end
    if (state_r == rssd_pkg::S_RESP && !ov_r && n_r == '0) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rssd_pkg::S_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
      n_r <= (state_r == rssd_pkg::S_RESP && !ov_r) ? '0 : n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    held_r <= held_nxt;
    ob_rec_r <= ob_rec_nxt;
    ob_st_r <= ob_st_nxt;
    ob_pos_r <= ob_pos_nxt;
    ob_last_r <= ob_last_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("count over depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == rssd_pkg::S_IDLE && !ov_r)
    else $error("accept while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rssd_pkg::S_INS_CMP) |-> j_r <= i_r)
    else $error("insert slot beyond index");
endmodule

>>> tb/sv/rssd_tb_pkg.sv
// rssd_tb_pkg: record beat type and the name-order helper for the checker.
// Depends on rssd_pkg.
package rssd_tb_pkg;
  import rssd_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [63:0] n0, n1, n2, n3, n4;
    logic [63:0] phone;
    logic [4:0]  position;
    logic        last;
  } result_beat_t;

  typedef struct packed {
    logic [319:0] name;
    logic [63:0]  phone;
  } phone_rec_t;

  // strict "a sorts after b", unsigned bytes, stop at first shared zero
  function automatic bit sorts_later(logic [319:0] a, logic [319:0] b);
    logic [7:0] x, y;
    for (int k = 0; k < NAME_BYTES; k++) begin
      x = a[319 - 8*k -: 8];
      y = b[319 - 8*k -: 8];
      if (x != y) return x > y;
      if (x == 8'd0) return 1'b0;
    end
    return 1'b0;
  endfunction
endpackage

>>> tb/sv/rssd_tb_chk.sv
// rssd_tb_chk: watches both channels, models the record stack, compares beats.
// Depends on rssd_pkg, rssd_tb_pkg, rssd_if.
module rssd_tb_chk #(
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  rssd_in_if   in_ch,
  rssd_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   beats_seen
);
  import rssd_pkg::*;
  import rssd_tb_pkg::*;

  phone_rec_t   stack_q[$];
  result_beat_t expected_q[$];

  function automatic result_beat_t status_beat(status_t s);
    result_beat_t b;
    b = '0;
    b.status = s;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic result_beat_t rec_beat(phone_rec_t r, int pos, bit lst);
    result_beat_t b;
    b = '0;
    b.status = ST_OK;
    {b.n0, b.n1, b.n2, b.n3, b.n4} = r.name;
    b.phone = r.phone;
    b.position = pos[4:0];
    b.last = lst;
    return b;
  endfunction

  task automatic predict_op(op_t op, phone_rec_t r);
    phone_rec_t sorted_q[$];
    phone_rec_t held;
    int j;
    case (op)
      OP_PUSH: begin
        if (stack_q.size() >= DEPTH) expected_q.push_back(status_beat(ST_FULL));
        else begin
          stack_q.push_back(r);
          expected_q.push_back(status_beat(ST_OK));
        end
      end
      OP_POP: begin
        if (stack_q.size() == 0) expected_q.push_back(status_beat(ST_EMPTY));
        else expected_q.push_back(rec_beat(stack_q.pop_back(), 0, 1'b1));
      end
      OP_DRAIN: begin
        if (stack_q.size() == 0) expected_q.push_back(status_beat(ST_EMPTY));
        else begin
          while (stack_q.size() > 0) sorted_q.push_back(stack_q.pop_back());
          for (int i = 1; i < sorted_q.size(); i++) begin
            held = sorted_q[i];
            j = i;
            while (j > 0 && sorts_later(sorted_q[j-1].name, held.name)) begin
              sorted_q[j] = sorted_q[j-1];
              j--;
            end
            sorted_q[j] = held;
          end
          foreach (sorted_q[i])
            expected_q.push_back(rec_beat(sorted_q[i], i, i == sorted_q.size() - 1));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    phone_rec_t   r;
    result_beat_t got, want;
    if (!rst_n) begin
      stack_q.delete();
      expected_q.delete();
      fail_count <= 0;
      beats_seen <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r.name = {in_ch.name_word_0, in_ch.name_word_1, in_ch.name_word_2,
                  in_ch.name_word_3, in_ch.name_word_4};
        r.phone = in_ch.phone_word;
        predict_op(op_t'(in_ch.operation), r);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.n0 = out_ch.out_name_0;
        got.n1 = out_ch.out_name_1;
        got.n2 = out_ch.out_name_2;
        got.n3 = out_ch.out_name_3;
        got.n4 = out_ch.out_name_4;
        got.phone = out_ch.out_phone;
        got.position = out_ch.position;
        got.last = out_ch.last;
        beats_seen <= beats_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch status exp %0d act %0d pos exp %0d act %0d last exp %0b act %0b",
                     $time, want.status, got.status, want.position, got.position,
                     want.last, got.last);
            $display("  name exp %h act %h", {want.n0, want.n1, want.n2, want.n3, want.n4},
                     {got.n0, got.n1, got.n2, got.n3, got.n4});
            $display("  phone exp %h act %h", want.phone, got.phone);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

>>> tb/sv/tb_top.sv
// tb_top: stimulus, clock/reset and verdict for record_stack_sorted_drain.
// Depends on rssd_pkg, rssd_tb_pkg, rssd_if, rssd_tb_chk and the block.
module tb_top;
  import rssd_pkg::*;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   fail_count, pending, beats_seen;
  int   items_sent = 0;
  bit   hold_off = 1'b0;   // forced long receiver stall

  rssd_in_if  in_ch();
  rssd_out_if out_ch();

  record_stack_sorted_drain #(.DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  rssd_tb_chk #(.DEPTH(DEPTH)) i_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .beats_seen(beats_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: fails the run once the cycle counter reaches CYCLE_LIMIT
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("record_stack_sorted_drain verification failed");
      $finish;
    end
  end

  // small alphabet of names so that ties and shared prefixes are common
  function automatic logic [319:0] pick_name();
    logic [319:0] nm;
    int len;
    nm = '0;
    case ($urandom_range(0, 9))
      0: nm = {$urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
      1: nm = '0;
      default: begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          nm[319 - 8*k -: 8] = 8'(8'h41 + $urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) nm[7:0] = 8'($urandom); // junk after the zero
      end
    endcase
    return nm;
  endfunction

  // one input beat; entered at a falling edge, optional random gap first
  task automatic send_beat(op_t op, logic [319:0] nm, logic [63:0] ph, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    {in_ch.name_word_0, in_ch.name_word_1, in_ch.name_word_2,
     in_ch.name_word_3, in_ch.name_word_4} <= nm;
    in_ch.phone_word <= ph;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_rand(op_t op);
    send_beat(op, pick_name(), {$urandom, $urandom});
  endtask

  // receiver: random stalls per beat, plus the forced hold-off
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else begin
        stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid && !hold_off) @(posedge clk);
      end
    end
  end

  initial begin
    int wait_cnt;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PUSH;
    {in_ch.name_word_0, in_ch.name_word_1, in_ch.name_word_2,
     in_ch.name_word_3, in_ch.name_word_4, in_ch.phone_word} = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop/drain, ignored code, extremes, full stack, ties
    send_rand(OP_POP);
    send_rand(OP_DRAIN);
    send_beat(OP_NONE, '1, '1);
    send_beat(OP_PUSH, '1, '1);
    send_beat(OP_PUSH, '0, '0);
    send_beat(OP_PUSH, {8'h41, 312'h0}, 64'h1);
    send_beat(OP_PUSH, {8'h41, 312'h0}, 64'h2);       // equal name, newer first
    send_beat(OP_PUSH, {8'h41, 8'h00, 304'h5}, 64'h3); // junk past terminator
    send_beat(OP_PUSH, {8'h80, 312'h0}, 64'h4);       // unsigned byte compare
    send_beat(OP_POP, '0, '0);
    send_beat(OP_DRAIN, '0, '0);
    // fill past DEPTH while the receiver holds off: block must stall input
    hold_off = 1'b1;
    fork
      begin
        wait_cnt = 0;
        while (wait_cnt < 300) begin @(posedge clk); wait_cnt++; end
        hold_off = 1'b0;
      end
      for (int k = 0; k < DEPTH + 2; k++) send_rand(OP_PUSH);
    join
    send_rand(OP_DRAIN);

    // random: mostly push bursts followed by drain or pops
    while (items_sent < 330) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_rand(OP_PUSH);
        5, 6:          send_rand(OP_POP);
        7:             send_rand(OP_DRAIN);
        8: begin
          repeat ($urandom_range(1, 12)) send_rand(OP_PUSH);
          send_rand(OP_DRAIN);
        end
        default:       send_rand(op_t'($urandom_range(0, 3)));
      endcase
    end
    send_rand(OP_DRAIN);
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 50000) begin @(posedge clk); wait_cnt++; end
    repeat (50) @(posedge clk);
    $display("sent %0d operations (push/pop/drain, full and empty cases), %0d result beats checked",
             items_sent, beats_seen);
    if (fail_count == 0 && pending == 0)
      $display("record_stack_sorted_drain verification clean");
    else
      $display("record_stack_sorted_drain verification failed");
    $finish;
  end
endmodule
